// ===== rtl/ktsc_pkg.sv =====
// Shared types, constants and symbol mapping functions for the keyword table shift cipher.
// No dependencies; used by keyword_table_shift_cipher.
package ktsc_pkg;

	localparam int ALPHA_SIZE  = 40;
	localparam int SYM_W       = 6;
	localparam int CHAR_W      = 8;
	localparam int LEN_W       = 4;
	localparam int SHIFT_W     = 6;
	localparam int CFG_IDX_W   = 2;
	localparam int KEY_MAX_DEF = 10;
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_SYMBOLS = 2'd0,
		CFG_KEY_LENGTH  = 2'd1,
		CFG_ROW_SHIFT   = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		RB_IDLE,
		RB_KEY,
		RB_REST
	} rb_state_t;

	typedef struct packed {
		logic             hit;
		logic [SYM_W-1:0] sym;
	} sym_lookup_t;

	function automatic sym_lookup_t ascii_to_sym(input logic [CHAR_W-1:0] c);
		sym_lookup_t r;
		r.hit = 1'b1;
		r.sym = '0;
		case (c) inside
			[8'h41:8'h5A]: r.sym = 6'(c - 8'h41);
			8'h20:         r.sym = 6'd26;
			8'h2C:         r.sym = 6'd27;
			8'h2E:         r.sym = 6'd28;
			[8'h30:8'h39]: r.sym = 6'(c - 8'h30 + 8'd29);
			8'h5F:         r.sym = 6'd39;
			default:       r.hit = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] sym_to_ascii(input logic [SYM_W-1:0] s);
		logic [CHAR_W-1:0] c;
		case (s) inside
			[6'd0:6'd25]:  c = 8'h41 + 8'(s);
			6'd26:         c = 8'h20;
			6'd27:         c = 8'h2C;
			6'd28:         c = 8'h2E;
			[6'd29:6'd38]: c = 8'h30 + 8'(s - 6'd29);
			6'd39:         c = 8'h5F;
			default:       c = 8'h5F;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/keyword_table_shift_cipher.sv =====
// Keyword table shift cipher: table rebuild sequencer, table memories and two-stage datapath.
// Depends on ktsc_pkg.
//
// Usage:
// Input channel (in_valid/in_ready) carries mode and char_in; output channel
// (out_valid/out_ready) carries char_out. One result per accepted transaction.
// An accepted input passes the stage one and then the stage two register before
// out_valid rises. Throughput: one transaction per cycle while no rebuild runs
// and the receiver does not stall; stage one reads the symbol position memory,
// stage two reads the mixed table memory, each a single registered port read.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index (0 key
// symbols, 1 key length, 2 row shift); other indexes are ignored.
// After reset and after every accepted register write the mixed table and its
// inverse are rebuilt, one candidate symbol per cycle: first the key symbols up to
// min(key_length, KEY_MAX), then the remaining alphabet. in_ready stays low while
// the rebuild runs; reset starts a rebuild that loads the plain alphabet order.
// When the receiver stalls, stage two holds its result and stage one fills;
// in_ready then drops until the output transaction completes.
module keyword_table_shift_cipher
	import ktsc_pkg::*;
#(
	parameter int KeyMax = KEY_MAX_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [SYM_W*KeyMax-1:0] cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   mode,
	input  logic [CHAR_W-1:0]      char_in,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [CHAR_W-1:0]      char_out
);

	localparam int KeyW = SYM_W * KeyMax;

	logic [KeyW-1:0]    key_q;
	logic [LEN_W-1:0]   key_len_q;
	logic [SHIFT_W-1:0] shift_q;
	logic               cfg_hit;
	logic [SHIFT_W-1:0] shift_wr;

	rb_state_t          rb_state_q, rb_state_d;
	logic [ALPHA_SIZE-1:0] taken_q;
	logic [SYM_W-1:0]   fill_q;
	logic [LEN_W-1:0]   key_idx_q;
	logic [SYM_W-1:0]   rest_sym_q;
	logic [LEN_W-1:0]   key_count;
	logic [SYM_W-1:0]   key_sym;
	logic               wr_en;
	logic [SYM_W-1:0]   wr_sym;
	logic               key_step;
	logic               rest_step;

	logic [SYM_W-1:0]   mixed_mem [ALPHA_SIZE];
	logic [SYM_W-1:0]   pos_mem   [ALPHA_SIZE];

	sym_lookup_t        in_lookup;
	logic               load_s1, adv_s2, ready_s1, ready_s2;
	logic               valid_s1, mode_s1, hit_s1;
	logic [CHAR_W-1:0]  char_s1;
	logic [SYM_W-1:0]   pos_rd_s1;
	logic               valid_s2, hit_s2;
	logic [CHAR_W-1:0]  char_s2;
	logic [SYM_W-1:0]   mixed_rd_s2;
	logic [SYM_W:0]     pos_fwd, pos_bwd, pos_sel;
	logic [SYM_W-1:0]   tbl_addr;

	// configuration registers
	assign cfg_hit = cfg_wr_en && (cfg_index == CFG_KEY_SYMBOLS ||
		cfg_index == CFG_KEY_LENGTH || cfg_index == CFG_ROW_SHIFT);
	assign shift_wr = cfg_data[SHIFT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q     <= '0;
			key_len_q <= '0;
			shift_q   <= SHIFT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_KEY_SYMBOLS: key_q <= cfg_data;
				CFG_KEY_LENGTH:  key_len_q <= cfg_data[LEN_W-1:0];
				CFG_ROW_SHIFT: begin
					if (shift_wr >= SHIFT_W'(ALPHA_SIZE))
						shift_q <= shift_wr - SHIFT_W'(ALPHA_SIZE);
					else
						shift_q <= shift_wr;
				end
				default: ;
			endcase
		end
	end

	// rebuild sequencer
	assign key_count = (key_len_q > LEN_W'(KeyMax)) ? LEN_W'(KeyMax) : key_len_q;

	always_comb begin
		key_sym = '0;
		for (int k = 0; k < KeyMax; k++) begin
			if (key_idx_q == LEN_W'(k))
				key_sym = key_q[k*SYM_W +: SYM_W];
		end
	end

	always_comb begin
		rb_state_d = rb_state_q;
		case (rb_state_q)
			RB_IDLE: ;
			RB_KEY: begin
				if (key_idx_q == key_count)
					rb_state_d = RB_REST;
			end
			RB_REST: begin
				if (rest_sym_q == SYM_W'(ALPHA_SIZE - 1))
					rb_state_d = RB_IDLE;
			end
			default: rb_state_d = RB_IDLE;
		endcase
		if (cfg_hit)
			rb_state_d = RB_KEY;
	end

	always_comb begin
		wr_en     = 1'b0;
		wr_sym    = '0;
		key_step  = 1'b0;
		rest_step = 1'b0;
		case (rb_state_q)
			RB_IDLE: ;
			RB_KEY: begin
				if (key_idx_q != key_count) begin
					key_step = 1'b1;
					wr_sym   = key_sym;
					if (key_sym < SYM_W'(ALPHA_SIZE) && !taken_q[key_sym])
						wr_en = 1'b1;
				end
			end
			RB_REST: begin
				rest_step = 1'b1;
				wr_sym    = rest_sym_q;
				wr_en     = !taken_q[rest_sym_q];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rb_state_q <= RB_KEY;
			taken_q    <= '0;
			fill_q     <= '0;
			key_idx_q  <= '0;
			rest_sym_q <= '0;
		end else begin
			rb_state_q <= rb_state_d;
			if (cfg_hit) begin
				taken_q    <= '0;
				fill_q     <= '0;
				key_idx_q  <= '0;
				rest_sym_q <= '0;
			end else begin
				if (wr_en) begin
					taken_q[wr_sym] <= 1'b1;
					fill_q          <= fill_q + 1'b1;
				end
				if (key_step)
					key_idx_q <= key_idx_q + 1'b1;
				if (rest_step)
					rest_sym_q <= rest_sym_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && !cfg_hit) begin
			mixed_mem[fill_q] <= wr_sym;
			pos_mem[wr_sym]   <= fill_q;
		end
	end

	// datapath handshake
	assign ready_s2 = !valid_s2 || out_ready;
	assign adv_s2   = valid_s1 && ready_s2;
	assign ready_s1 = !valid_s1 || adv_s2;
	assign in_ready = ready_s1 && (rb_state_q == RB_IDLE);
	assign load_s1  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1)
				valid_s1 <= 1'b1;
			else if (adv_s2)
				valid_s1 <= 1'b0;
			if (adv_s2)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	// stage one: locate the symbol in the mixed table
	assign in_lookup = ascii_to_sym(char_in);

	always_ff @(posedge clk) begin
		if (load_s1) begin
			mode_s1   <= mode;
			char_s1   <= char_in;
			hit_s1    <= in_lookup.hit;
			pos_rd_s1 <= pos_mem[in_lookup.sym];
		end
	end

	// stage two: move along the table and read the substitute
	assign pos_fwd  = {1'b0, pos_rd_s1} + {1'b0, shift_q};
	assign pos_bwd  = {1'b0, pos_rd_s1} + (SYM_W+1)'(ALPHA_SIZE) - {1'b0, shift_q};
	assign pos_sel  = mode_s1 ? pos_bwd : pos_fwd;
	assign tbl_addr = (pos_sel >= (SYM_W+1)'(ALPHA_SIZE)) ?
		SYM_W'(pos_sel - (SYM_W+1)'(ALPHA_SIZE)) : pos_sel[SYM_W-1:0];

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			char_s2     <= char_s1;
			hit_s2      <= hit_s1;
			mixed_rd_s2 <= mixed_mem[tbl_addr];
		end
	end

	assign out_valid = valid_s2;
	assign char_out  = hit_s2 ? sym_to_ascii(mixed_rd_s2) : char_s2;

endmodule
